@@ rtl/dst40_pkg.sv @@
// dst40 cipher package: widths, bit tables and the round function
package dst40_pkg;

  localparam int unsigned DataW  = 40;
  localparam int unsigned SigW   = 24;
  localparam int unsigned RoundW = 8;
  localparam int unsigned PhaseW = 2;

  // key schedule phase: first key shift after round 2, then every third round
  localparam logic [PhaseW-1:0] PHASE_START  = 2'd2;
  localparam logic [PhaseW-1:0] PHASE_RELOAD = 2'd3;
  localparam logic [PhaseW-1:0] PHASE_LAST   = 2'd1;

  // 5-input bit tables, bit i is f(i)
  localparam logic [31:0] FN_A = 32'h3A35ACC5;
  localparam logic [31:0] FN_B = 32'hAC35742E;
  localparam logic [31:0] FN_C = 32'hB81D8BD1;
  localparam logic [31:0] FN_D = 32'h5ACC335A;
  // 4-input bit tables
  localparam logic [15:0] FN_E = 16'hE247;
  localparam logic [15:0] FN_G = 16'h4E72;

  // final 2-bit output function
  function automatic logic [1:0] fn_h(logic [3:0] sel);
    logic [1:0] res;
    case (sel)
      4'd0:    res = 2'd0;
      4'd1:    res = 2'd1;
      4'd2:    res = 2'd3;
      4'd3:    res = 2'd3;
      4'd4:    res = 2'd2;
      4'd5:    res = 2'd1;
      4'd6:    res = 2'd2;
      4'd7:    res = 2'd0;
      4'd8:    res = 2'd0;
      4'd9:    res = 2'd2;
      4'd10:   res = 2'd1;
      4'd11:   res = 2'd2;
      4'd12:   res = 2'd3;
      4'd13:   res = 2'd3;
      4'd14:   res = 2'd1;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

  // low group taps at position p
  function automatic logic [4:0] low_idx(logic [DataW-1:0] k, logic [DataW-1:0] r,
                                         int unsigned p);
    return {k[16+p], r[8+p], k[8+p], r[p], k[p]};
  endfunction

  // high group taps at position p
  function automatic logic [4:0] high_idx(logic [DataW-1:0] k, logic [DataW-1:0] r,
                                          int unsigned p);
    return {r[32+p], k[32+p], r[24+p], k[24+p], r[16+p]};
  endfunction

  // 4-input taps at position p
  function automatic logic [3:0] quad_idx(logic [DataW-1:0] k, logic [DataW-1:0] r,
                                          int unsigned p);
    return {k[16+p], r[8+p], k[8+p], k[p]};
  endfunction

  // pair combiner, p is the upper position of the pair
  function automatic logic [3:0] combine(logic [DataW-1:0] k, logic [DataW-1:0] r,
                                         int unsigned p);
    return {FN_A[low_idx(k, r, p)], FN_B[high_idx(k, r, p)],
            FN_C[low_idx(k, r, p - 1)], FN_D[high_idx(k, r, p - 1)]};
  endfunction

  // 2-bit nonlinear output of one round
  function automatic logic [1:0] round_fn(logic [DataW-1:0] k, logic [DataW-1:0] r);
    logic [3:0] na;
    logic [3:0] nb;
    logic [3:0] nc;
    logic [3:0] nd;
    logic [3:0] sel;
    na  = combine(k, r, 7);
    nc  = combine(k, r, 5);
    nb  = combine(k, r, 3);
    nd  = {FN_E[quad_idx(k, r, 1)], FN_B[high_idx(k, r, 1)],
           FN_E[quad_idx(k, r, 0)], FN_D[high_idx(k, r, 0)]};
    sel = {FN_G[nd], FN_G[nb], FN_G[nc], FN_G[na]};
    return fn_h(sel);
  endfunction

endpackage

@@ rtl/transponder_signature_cipher_40.sv @@
// dst40 transponder signature cipher, one round per cycle
//
// Usage: an input transaction carries challenge, secret_key and round_count
// over in_valid / in_stall. The block then runs round_count rounds through
// a single round unit, one round per clock, under a small sequencer, and
// presents signature, final_challenge and final_key over out_valid /
// out_stall.
// Sequence: the transaction is loaded on acceptance, then the round loop
// checks the remaining count before each round and moves to the done state,
// which raises out_valid, once it reaches zero. A new transaction is only
// accepted after the previous result has been taken, as the single round
// unit serves one transaction at a time.
// in_stall is high whenever a transaction is in progress or its result
// is still waiting; only one transaction is held at a time.
// When the receiver raises out_stall the result holds stable on the
// output ports until it is taken.
// Reset (rst, synchronous, active high) returns the sequencer to idle and
// drops out_valid; any transaction in flight is lost.
module transponder_signature_cipher_40 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dst40_pkg::DataW-1:0]       challenge,
  input  logic [dst40_pkg::DataW-1:0]       secret_key,
  input  logic [dst40_pkg::RoundW-1:0]      round_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dst40_pkg::SigW-1:0]        signature,
  output logic [dst40_pkg::DataW-1:0]       final_challenge,
  output logic [dst40_pkg::DataW-1:0]       final_key
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [dst40_pkg::DataW-1:0]         chal;
  logic [dst40_pkg::DataW-1:0]         key;
  logic [dst40_pkg::RoundW-1:0]        remaining;
  logic [dst40_pkg::PhaseW-1:0]        phase;
  logic [1:0]                          h_out;
  logic [1:0]                          feedback;
  logic                                key_bit;
  logic                                in_fire;
  logic                                out_fire;
  logic                                round_en;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign round_en = (state == ST_RUN) && (remaining != '0);

  // shared round unit
  assign h_out    = dst40_pkg::round_fn(key, chal);
  assign feedback = h_out ^ chal[1:0];
  assign key_bit  = key[0] ^ key[2] ^ key[19] ^ key[21];

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (remaining == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath: load on accept, one round per cycle while running
  always_ff @(posedge clk) begin
    if (in_fire) begin
      chal      <= challenge;
      key       <= secret_key;
      remaining <= round_count;
      phase     <= dst40_pkg::PHASE_START;
    end else if (round_en) begin
      chal      <= {feedback, chal[dst40_pkg::DataW-1:2]};
      remaining <= remaining - 1'b1;
      if (phase == dst40_pkg::PHASE_LAST) begin
        phase <= dst40_pkg::PHASE_RELOAD;
        key   <= {key_bit, key[dst40_pkg::DataW-1:1]};
      end else begin
        phase <= phase - 1'b1;
      end
    end
  end

  // handshake and result ports
  assign in_stall        = (state != ST_IDLE);
  assign out_valid       = (state == ST_DONE);
  assign signature       = chal[dst40_pkg::SigW-1:0];
  assign final_challenge = chal;
  assign final_key       = key;

endmodule

@@ bench/tb_top.sv @@
// testbench for the dst40 transponder signature cipher: self-predicting, random and directed
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = dst40_pkg::DataW;
  localparam int SW = dst40_pkg::SigW;
  localparam int NW = dst40_pkg::RoundW;

  localparam int NUM_ITEMS   = 1950;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2500;
  localparam int DRAIN_WAIT  = 300;

  // cipher bit tables, bit i is f(i)
  localparam logic [31:0] TBL_A = 32'h3A35ACC5;
  localparam logic [31:0] TBL_B = 32'hAC35742E;
  localparam logic [31:0] TBL_C = 32'hB81D8BD1;
  localparam logic [31:0] TBL_D = 32'h5ACC335A;
  localparam logic [15:0] TBL_E = 16'hE247;
  localparam logic [15:0] TBL_G = 16'h4E72;
  localparam logic [1:0]  H_MAP [0:15] = '{2'd0, 2'd1, 2'd3, 2'd3, 2'd2, 2'd1, 2'd2, 2'd0,
                                          2'd0, 2'd2, 2'd1, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0};

  typedef struct packed {
    logic [DW-1:0] chal;
    logic [DW-1:0] key;
    logic [NW-1:0] rounds;
  } sig_item_t;

  typedef struct packed {
    logic [SW-1:0] sig;
    logic [DW-1:0] chal;
    logic [DW-1:0] key;
  } sig_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [DW-1:0] challenge = '0;
  logic [DW-1:0] secret_key = '0;
  logic [NW-1:0] round_count = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [SW-1:0] signature;
  logic [DW-1:0] final_challenge;
  logic [DW-1:0] final_key;

  sig_item_t   pend_q[$];
  sig_result_t sig_q[$];
  int          n_items = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_err = 0;
  bit          in_took = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          quiet_cycles = 0;

  transponder_signature_cipher_40 i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .challenge       (challenge),
    .secret_key      (secret_key),
    .round_count     (round_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .signature       (signature),
    .final_challenge (final_challenge),
    .final_key       (final_key)
  );

  always #6 clk = ~clk;

  // five-bit tap vector of the low group at position p
  function automatic logic [4:0] low_taps(logic [DW-1:0] k, logic [DW-1:0] c, int p);
    return {k[16+p], c[8+p], k[8+p], c[p], k[p]};
  endfunction

  // five-bit tap vector of the high group at position p
  function automatic logic [4:0] high_taps(logic [DW-1:0] k, logic [DW-1:0] c, int p);
    return {c[32+p], k[32+p], c[24+p], k[24+p], c[16+p]};
  endfunction

  // four-bit taps for the lowest pair
  function automatic logic [3:0] quad_taps(logic [DW-1:0] k, logic [DW-1:0] c, int p);
    return {k[16+p], c[8+p], k[8+p], k[p]};
  endfunction

  // 2-bit nonlinear output of one round
  function automatic logic [1:0] round_bits(logic [DW-1:0] k, logic [DW-1:0] c);
    logic [3:0] grp [0:2];
    logic [3:0] low_pair;
    logic [3:0] sel;
    int         p;
    for (int g = 0; g < 3; g++) begin
      p = 7 - 2 * g;
      grp[g] = {TBL_A[low_taps(k, c, p)], TBL_B[high_taps(k, c, p)],
                TBL_C[low_taps(k, c, p - 1)], TBL_D[high_taps(k, c, p - 1)]};
    end
    low_pair = {TBL_E[quad_taps(k, c, 1)], TBL_B[high_taps(k, c, 1)],
                TBL_E[quad_taps(k, c, 0)], TBL_D[high_taps(k, c, 0)]};
    sel = {TBL_G[low_pair], TBL_G[grp[2]], TBL_G[grp[1]], TBL_G[grp[0]]};
    return H_MAP[sel];
  endfunction

  // full signature computation for one transaction
  function automatic sig_result_t dst40_sign(logic [DW-1:0] c, logic [DW-1:0] k,
                                             logic [NW-1:0] n);
    sig_result_t res;
    logic [1:0]  fb;
    for (int i = 0; i < int'(n); i++) begin
      fb = round_bits(k, c) ^ c[1:0];
      c  = {fb, c[DW-1:2]};
      // key steps after rounds 2, 5, 8, ...
      if (i % 3 == 1) k = {k[0] ^ k[2] ^ k[19] ^ k[21], k[DW-1:1]};
    end
    res.sig  = c[SW-1:0];
    res.chal = c;
    res.key  = k;
    return res;
  endfunction

  // random 40-bit value with a mix of bit densities
  function automatic logic [DW-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(0, DW - 1);
      3:       w = w & {$urandom, $urandom} & {$urandom, $urandom};
      4:       w = w | {$urandom, $urandom} | {$urandom, $urandom};
      default: ;
    endcase
    return w[DW-1:0];
  endfunction

  // round count, mostly short so the run stays quick
  function automatic logic [NW-1:0] rand_rounds();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return NW'($urandom_range(0, 15));
    if (sel < 17) return NW'(200);
    if (sel < 19) return NW'($urandom_range(0, 255));
    return NW'($urandom_range(250, 255));
  endfunction

  task automatic add_item(logic [DW-1:0] c, logic [DW-1:0] k, logic [NW-1:0] n);
    sig_item_t it;
    it.chal   = c;
    it.key    = k;
    it.rounds = n;
    pend_q.push_back(it);
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin : drive_p
    sig_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled, hold the payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pend_q.size() > 0) begin
      nxt = pend_q.pop_front();
      challenge   <= nxt.chal;
      secret_key  <= nxt.key;
      round_count <= nxt.rounds;
      in_valid    <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end
    end else begin
      in_valid <= 1'b0;
    end
    in_took = 1'b0;
  end

  // input side: predict the result of each accepted transaction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sig_q.push_back(dst40_sign(challenge, secret_key, round_count));
      in_took = 1'b1;
      n_in++;
    end
  end

  // receiver: changing stall pattern plus two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && n_out >= ((holds_done == 0) ? 150 : 1200)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // output side: compare against the oldest predicted signature
  always @(posedge clk) begin : check_p
    sig_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_out++;
      if (sig_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        n_err++;
      end else begin
        want = sig_q.pop_front();
        if (signature !== want.sig) begin
          $error("signature: expected %h, got %h", want.sig, signature);
          n_err++;
        end
        if (final_challenge !== want.chal) begin
          $error("final_challenge: expected %h, got %h", want.chal, final_challenge);
          n_err++;
        end
        if (final_key !== want.key) begin
          $error("final_key: expected %h, got %h", want.key, final_key);
          n_err++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // directed: extremes, zero rounds, key schedule edges
    add_item('0, '0, 8'd0);
    add_item('0, '0, 8'd200);
    add_item('1, '1, 8'd200);
    add_item('1, '1, 8'd255);
    add_item('1, '1, 8'd0);
    add_item(rand_word(), rand_word(), 8'd0);
    add_item(rand_word(), rand_word(), 8'd1);
    add_item(rand_word(), rand_word(), 8'd2);
    add_item(rand_word(), rand_word(), 8'd3);
    add_item(rand_word(), rand_word(), 8'd5);
    add_item(rand_word(), rand_word(), 8'd6);
    add_item('1, '0, 8'd200);
    add_item('0, '1, 8'd200);
    add_item(40'hAAAAAAAAAA, 40'h5555555555, 8'd200);
    add_item(40'h5555555555, 40'hAAAAAAAAAA, 8'd255);
    add_item(40'h0000000001, 40'h8000000000, 8'd200);
    add_item(40'h8000000000, 40'h0000000001, 8'd200);
    add_item(rand_word(), rand_word(), 8'd255);
    add_item(rand_word(), rand_word(), 8'd254);
    add_item('0, '0, 8'd255);
    add_item(40'h0123456789, 40'hFEDCBA9876, 8'd200);
    // random
    while (pend_q.size() < NUM_ITEMS) add_item(rand_word(), rand_word(), rand_rounds());
    n_items = pend_q.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_in < n_items) @(posedge clk);
    while (sig_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_err == 0 && sig_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
